@@ rtl/core/tpa_pkg.sv @@
// Shared widths, codes and types of the transpose pack/unpack addresser.
package tpa_pkg;

  localparam int unsigned MAX_ELEMENTS = 65536;

  localparam int unsigned IDX_W   = 16;  // element index
  localparam int unsigned DATA_W  = 64;  // one raw double
  localparam int unsigned MODE_W  = 2;
  localparam int unsigned DOM_W   = 7;   // rows / cols per domain
  localparam int unsigned EXT_W   = 13;  // line extent
  localparam int unsigned CFG_W   = 13;  // widest register
  localparam int unsigned CIDX_W  = 2;
  localparam int unsigned DIV_W   = 21;  // widest divisor, R*R*C or R*C*C
  localparam int unsigned TOT_W   = 27;  // R*C*E
  localparam int unsigned PROD_W  = IDX_W + DIV_W;
  localparam int unsigned SUM_W   = PROD_W + 2;
  localparam int unsigned DIV_LAT = IDX_W;  // one quotient bit per stage

  typedef enum logic [MODE_W-1:0] {
    MODE_ROW_PACK   = 2'd0,
    MODE_COL_PACK   = 2'd1,
    MODE_ROW_UNPACK = 2'd2,
    MODE_COL_UNPACK = 2'd3
  } tpa_mode_e;

  typedef enum logic [CIDX_W-1:0] {
    REG_MODE = 2'd0,
    REG_ROWS = 2'd1,
    REG_COLS = 2'd2,
    REG_EXT  = 2'd3
  } tpa_reg_e;

  // Config, products; user keeps stable while requests in flight; unchecked
  typedef struct packed {
    tpa_mode_e          mode;
    logic [DOM_W-1:0]   r;
    logic [DOM_W-1:0]   c;
    logic [EXT_W-1:0]   e;
    logic [2*DOM_W-1:0] rr;
    logic [2*DOM_W-1:0] rc;
    logic [DOM_W+EXT_W-1:0] re;
    logic [DIV_W-1:0]   rrc;
    logic [DIV_W-1:0]   rcc;
    logic [TOT_W-1:0]   rce;
    logic               zero;
  } tpa_cfg_t;

  typedef struct packed {
    logic [IDX_W-1:0]  idx;
    logic [DATA_W-1:0] re;
    logic [DATA_W-1:0] im;
  } tpa_elem_t;

  typedef struct packed {
    tpa_elem_t        elem;
    logic [IDX_W-1:0] rem_x;
    logic [IDX_W-1:0] rem_y;
    logic [IDX_W-1:0] quo_z;
  } tpa_mid_t;

endpackage

@@ rtl/core/tpa_stream_if.sv @@
// Valid/ready stream interfaces for element requests and results.
interface tpa_in_if;
  import tpa_pkg::*;
  logic              valid;
  logic              ready;
  logic [IDX_W-1:0]  source_index;
  logic [DATA_W-1:0] value_real;
  logic [DATA_W-1:0] value_imag;
  modport source (output valid, source_index, value_real, value_imag, input ready);
  modport sink   (input valid, source_index, value_real, value_imag, output ready);
endinterface

interface tpa_out_if;
  import tpa_pkg::*;
  logic              valid;
  logic              ready;
  logic [IDX_W-1:0]  dest_index;
  logic [DATA_W-1:0] out_real;
  logic [DATA_W-1:0] out_imag;
  logic              range_error;
  modport source (output valid, dest_index, out_real, out_imag, range_error, input ready);
  modport sink   (input valid, dest_index, out_real, out_imag, range_error, output ready);
endinterface

@@ rtl/core/transpose_pack_unpack_addresser.sv @@
// Top level: pencil transpose pack/unpack address pipeline.
//
//   channel  | dir | payload                                        | handshake
//   in_if    | in  | source_index, value_real, value_imag           | valid/ready
//   out_if   | out | dest_index, out_real, out_imag, range_error    | valid/ready
//   cfg      | in  | cfg_idx_i, cfg_data_i                          | cfg_we_i
//
// One request per cycle unless the result is held; requests pass input/staging regs,
// two chained divider levels (one quotient bit per stage), product and output regs.
// Derived size products settle in registered steps after a register write.
// Reset clears valid bits and configuration; payload stages are not reset.
// A stalled result freezes the whole pipeline, so nothing is lost or repeated.
module transpose_pack_unpack_addresser
  import tpa_pkg::*;
(
  input  logic              clk_i,
  input  logic              rst_ni,
  tpa_in_if.sink            in_if,
  tpa_out_if.source         out_if,
  input  logic              cfg_we_i,
  input  logic [CIDX_W-1:0] cfg_idx_i,
  input  logic [CFG_W-1:0]  cfg_data_i
);

  tpa_cfg_t cfg;
  logic     adv;

  tpa_cfg u_cfg (
    .clk_i, .rst_ni, .cfg_we_i, .cfg_idx_i, .cfg_data_i, .cfg_o(cfg)
  );

  // Advance every stage unless the result is held
  assign adv         = !out_if.valid || out_if.ready;
  assign in_if.ready = adv;

  // Input and staging registers
  tpa_elem_t s0_q, s1_q;
  logic      s0_v_q, s1_v_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s0_v_q <= 1'b0;
      s1_v_q <= 1'b0;
    end else if (adv) begin
      s0_v_q <= in_if.valid;
      s1_v_q <= s0_v_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv) begin
      s0_q <= '{idx: in_if.source_index, re: in_if.value_real, im: in_if.value_imag};
      s1_q <= s0_q;
    end
  end

  // First division level: by R or C, by E, and by the block size
  logic [DIV_W-1:0] div_x, div_z;
  logic [IDX_W-1:0] q_x, r_x, q_y, r_y, q_z, r_z;

  always_comb begin
    div_x = DIV_W'(cfg.r);
    div_z = DIV_W'(cfg.re);
    unique case (cfg.mode) inside
      MODE_ROW_PACK, MODE_COL_PACK: div_z = DIV_W'(cfg.re);
      MODE_ROW_UNPACK:              div_z = cfg.rrc;
      MODE_COL_UNPACK: begin
        div_x = DIV_W'(cfg.c);
        div_z = cfg.rcc;
      end
      default: ;
    endcase
  end

  tpa_div_lane u_div_x (.clk_i, .en_i(adv), .dividend_i(s1_q.idx), .divisor_i(div_x),
                        .quot_o(q_x), .rem_o(r_x));
  tpa_div_lane u_div_y (.clk_i, .en_i(adv), .dividend_i(s1_q.idx),
                        .divisor_i(DIV_W'(cfg.e)), .quot_o(q_y), .rem_o(r_y));
  tpa_div_lane u_div_z (.clk_i, .en_i(adv), .dividend_i(s1_q.idx), .divisor_i(div_z),
                        .quot_o(q_z), .rem_o(r_z));

  tpa_elem_t sb1_q [DIV_LAT];
  logic [DIV_LAT-1:0] v1_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v1_q <= '0;
    end else if (adv) begin
      v1_q <= {v1_q[DIV_LAT-2:0], s1_v_q};
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv) begin
      sb1_q[0] <= s1_q;
      for (int k = 1; k < DIV_LAT; k++) sb1_q[k] <= sb1_q[k-1];
    end
  end

  // Second division level on first-level results
  logic [IDX_W-1:0] dvd_q2;
  logic [DIV_W-1:0] div_q2;
  logic [IDX_W-1:0] q_p, r_p, q_w, r_w;

  always_comb begin
    dvd_q2 = q_y;
    div_q2 = DIV_W'(cfg.r);
    unique case (cfg.mode) inside
      MODE_ROW_PACK, MODE_COL_PACK: begin
        dvd_q2 = q_y;
        div_q2 = DIV_W'(cfg.r);
      end
      MODE_ROW_UNPACK, MODE_COL_UNPACK: begin
        dvd_q2 = q_x;
        div_q2 = DIV_W'(cfg.rc);
      end
      default: ;
    endcase
  end

  tpa_div_lane u_div_p (.clk_i, .en_i(adv), .dividend_i(r_y), .divisor_i(DIV_W'(cfg.r)),
                        .quot_o(q_p), .rem_o(r_p));
  tpa_div_lane u_div_q (.clk_i, .en_i(adv), .dividend_i(dvd_q2), .divisor_i(div_q2),
                        .quot_o(q_w), .rem_o(r_w));

  tpa_mid_t sb2_q [DIV_LAT];
  logic [DIV_LAT-1:0] v2_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v2_q <= '0;
    end else if (adv) begin
      v2_q <= {v2_q[DIV_LAT-2:0], v1_q[DIV_LAT-1]};
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv) begin
      sb2_q[0] <= '{elem: sb1_q[DIV_LAT-1], rem_x: r_x, rem_y: r_y, quo_z: q_z};
      for (int k = 1; k < DIV_LAT; k++) sb2_q[k] <= sb2_q[k-1];
    end
  end

  // Pick operands per formula and multiply
  tpa_mid_t         mid;
  logic [IDX_W-1:0] a1, a2, a3, add;
  logic [DIV_W-1:0] b1, b2, b3;

  assign mid = sb2_q[DIV_LAT-1];

  always_comb begin
    a1 = mid.rem_x;  b1 = DIV_W'(cfg.r);
    a2 = q_p;        b2 = cfg.rrc;
    a3 = mid.quo_z;  b3 = DIV_W'(cfg.rr);
    add = r_w;
    unique case (cfg.mode)
      MODE_ROW_PACK: begin
        a1 = mid.rem_x;  b1 = DIV_W'(cfg.r);
        a2 = q_p;        b2 = cfg.rrc;
        a3 = mid.quo_z;  b3 = DIV_W'(cfg.rr);
        add = r_w;
      end
      MODE_COL_PACK: begin
        a1 = mid.rem_y;  b1 = DIV_W'(cfg.rc);
        a2 = r_w;        b2 = DIV_W'(cfg.c);
        a3 = mid.quo_z;  b3 = DIV_W'(1);
        add = '0;
      end
      MODE_ROW_UNPACK: begin
        a1 = '0;         b1 = '0;
        a2 = r_w;        b2 = DIV_W'(cfg.e);
        a3 = mid.quo_z;  b3 = DIV_W'(cfg.r);
        add = mid.rem_x;
      end
      MODE_COL_UNPACK: begin
        a1 = '0;         b1 = '0;
        a2 = r_w;        b2 = DIV_W'(cfg.e);
        a3 = mid.quo_z;  b3 = DIV_W'(cfg.c);
        add = mid.rem_x;
      end
      default: ;
    endcase
  end

  logic [PROD_W-1:0] m1_q, m2_q, m3_q;
  logic [IDX_W-1:0]  add_q;
  tpa_elem_t         m_elem_q;
  logic              m_v_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      m_v_q <= 1'b0;
    end else if (adv) begin
      m_v_q <= v2_q[DIV_LAT-1];
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv) begin
      m1_q     <= PROD_W'(a1) * PROD_W'(b1);
      m2_q     <= PROD_W'(a2) * PROD_W'(b2);
      m3_q     <= PROD_W'(a3) * PROD_W'(b3);
      add_q    <= add;
      m_elem_q <= mid.elem;
    end
  end

  // Sum the terms and check the range
  logic [SUM_W-1:0] dest;
  logic             err;

  assign dest = SUM_W'(m1_q) + SUM_W'(m2_q) + SUM_W'(m3_q) + SUM_W'(add_q);
  assign err  = cfg.zero
             || (TOT_W'(m_elem_q.idx) >= cfg.rce)
             || (dest >= SUM_W'(cfg.rce))
             || (dest >= SUM_W'(MAX_ELEMENTS));

  logic              o_v_q;
  logic [IDX_W-1:0]  o_dest_q;
  logic              o_err_q;
  logic [DATA_W-1:0] o_re_q, o_im_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      o_v_q <= 1'b0;
    end else if (adv) begin
      o_v_q <= m_v_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv) begin
      o_dest_q <= cfg.zero ? '0 : dest[IDX_W-1:0];
      o_err_q  <= err;
      o_re_q   <= m_elem_q.re;
      o_im_q   <= m_elem_q.im;
    end
  end

  assign out_if.valid       = o_v_q;
  assign out_if.dest_index  = o_dest_q;
  assign out_if.out_real    = o_re_q;
  assign out_if.out_imag    = o_im_q;
  assign out_if.range_error = o_err_q;

  // Outputs of these lanes are not part of any formula
  logic unused_rem;
  assign unused_rem = ^{r_z, r_p, q_w};

endmodule

@@ rtl/core/tpa_cfg.sv @@
// Configuration registers and the products derived from them.
module tpa_cfg
  import tpa_pkg::*;
(
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              cfg_we_i,
  input  logic [CIDX_W-1:0] cfg_idx_i,
  input  logic [CFG_W-1:0]  cfg_data_i,
  output tpa_cfg_t          cfg_o
);

  tpa_mode_e              mode_q;
  logic [DOM_W-1:0]       rows_q, cols_q;
  logic [EXT_W-1:0]       ext_q;
  logic [2*DOM_W-1:0]     rr_q, rc_q;
  logic [DOM_W+EXT_W-1:0] re_q;
  logic [DIV_W-1:0]       rrc_q, rcc_q;
  logic [TOT_W-1:0]       rce_q;
  logic                   zero_q;

  // Decode register writes
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mode_q <= MODE_ROW_PACK;
      rows_q <= DOM_W'(1);
      cols_q <= DOM_W'(1);
      ext_q  <= EXT_W'(1);
    end else if (cfg_we_i) begin
      unique case (tpa_reg_e'(cfg_idx_i))
        REG_MODE: mode_q <= tpa_mode_e'(cfg_data_i[MODE_W-1:0]);
        REG_ROWS: rows_q <= cfg_data_i[DOM_W-1:0];
        REG_COLS: cols_q <= cfg_data_i[DOM_W-1:0];
        REG_EXT:  ext_q  <= cfg_data_i[EXT_W-1:0];
        default:  ;
      endcase
    end
  end

  // Build products in two registered steps, one multiply per step
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      rr_q   <= (2*DOM_W)'(1);
      rc_q   <= (2*DOM_W)'(1);
      re_q   <= (DOM_W+EXT_W)'(1);
      rrc_q  <= DIV_W'(1);
      rcc_q  <= DIV_W'(1);
      rce_q  <= TOT_W'(1);
      zero_q <= 1'b0;
    end else begin
      rr_q   <= (2*DOM_W)'(rows_q) * (2*DOM_W)'(rows_q);
      rc_q   <= (2*DOM_W)'(rows_q) * (2*DOM_W)'(cols_q);
      re_q   <= (DOM_W+EXT_W)'(rows_q) * (DOM_W+EXT_W)'(ext_q);
      rrc_q  <= DIV_W'(rr_q) * DIV_W'(cols_q);
      rcc_q  <= DIV_W'(rc_q) * DIV_W'(cols_q);
      rce_q  <= TOT_W'(re_q) * TOT_W'(cols_q);
      zero_q <= (rows_q == '0) || (cols_q == '0) || (ext_q == '0);
    end
  end

  assign cfg_o = '{mode: mode_q, r: rows_q, c: cols_q, e: ext_q, rr: rr_q, rc: rc_q,
                   re: re_q, rrc: rrc_q, rcc: rcc_q, rce: rce_q, zero: zero_q};

endmodule

@@ rtl/core/tpa_div_lane.sv @@
// Pipelined restoring divider: one quotient bit per stage.
module tpa_div_lane
  import tpa_pkg::*;
(
  input  logic             clk_i,
  input  logic             en_i,
  input  logic [IDX_W-1:0] dividend_i,
  input  logic [DIV_W-1:0] divisor_i,
  output logic [IDX_W-1:0] quot_o,
  output logic [IDX_W-1:0] rem_o
);

  logic [DIV_W-1:0] rem_q [DIV_LAT];
  logic [IDX_W-1:0] dvd_q [DIV_LAT];
  logic [IDX_W-1:0] quo_q [DIV_LAT];

  for (genvar k = 0; k < DIV_LAT; k++) begin : g_stage
    logic [DIV_W-1:0] rem_in;
    logic [IDX_W-1:0] dvd_in, quo_in;
    logic [DIV_W:0]   trial;
    logic             take;

    if (k == 0) begin : g_first
      assign rem_in = '0;
      assign dvd_in = dividend_i;
      assign quo_in = '0;
    end else begin : g_next
      assign rem_in = rem_q[k-1];
      assign dvd_in = dvd_q[k-1];
      assign quo_in = quo_q[k-1];
    end

    // Shift in the next dividend bit and subtract when it fits
    assign trial = {rem_in, dvd_in[IDX_W-1]};
    assign take  = trial >= {1'b0, divisor_i};

    always_ff @(posedge clk_i) begin
      if (en_i) begin
        rem_q[k] <= take ? DIV_W'(trial - {1'b0, divisor_i}) : DIV_W'(trial);
        dvd_q[k] <= {dvd_in[IDX_W-2:0], 1'b0};
        quo_q[k] <= {quo_in[IDX_W-2:0], take};
      end
    end
  end

  assign quot_o = quo_q[DIV_LAT-1];
  assign rem_o  = rem_q[DIV_LAT-1][IDX_W-1:0];

endmodule
